// ----- hw/rtl/hkle_pkg.sv -----
`timescale 1ns / 1ps

package hkle_pkg;

  // Report kinds and key codes
  localparam logic [1:0] KIND_PRESS    = 2'd2;
  localparam logic [7:0] KEY_NONE      = 8'd0;
  localparam logic [7:0] KEY_ENTER     = 8'd40;
  localparam logic [7:0] KEY_BACKSPACE = 8'd42;
  localparam logic [7:0] CHAR_NONE     = 8'h00;
  localparam logic [7:0] CHAR_SLASH    = 8'h2F;
  localparam int         CHUNK_CHARS   = 8;

  // Work items passed from the front end to the line engine
  typedef enum logic [1:0] {
    OP_CHAR,
    OP_ENTER,
    OP_BKSP
  } key_op_kind_t;

  typedef struct packed {
    key_op_kind_t kind;
    logic [7:0]   ch;
  } key_op_t;

  // Line engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADDR,
    BK_DATA,
    BK_OUT
  } back_state_t;

  // Unshifted character for a key code; zero where the key has no character
  function automatic logic [7:0] plain_char(input logic [7:0] code);
    logic [7:0] c;
    c = CHAR_NONE;
    if (code >= 8'd4 && code <= 8'd29) begin
      c = code + 8'h5D;
    end else if (code >= 8'd30 && code <= 8'd38) begin
      c = code + 8'h13;
    end else begin
      case (code)
        8'd39:   c = 8'h30;
        8'd44:   c = 8'h20;
        8'd45:   c = 8'h2D;
        8'd46:   c = 8'h3D;
        8'd47:   c = 8'h5B;
        8'd48:   c = 8'h5D;
        8'd49:   c = 8'h3F;
        8'd50:   c = 8'h5C;
        8'd51:   c = 8'h3B;
        8'd52:   c = 8'h27;
        8'd53:   c = 8'h7E;
        8'd54:   c = 8'h2C;
        8'd55:   c = 8'h2E;
        8'd56:   c = CHAR_SLASH;
        default: c = CHAR_NONE;
      endcase
    end
    return c;
  endfunction

  // Shifted character for a key code; zero where the key has no character
  function automatic logic [7:0] shift_char(input logic [7:0] code);
    logic [7:0] c;
    c = CHAR_NONE;
    if (code >= 8'd4 && code <= 8'd29) begin
      c = code + 8'h3D;
    end else begin
      case (code)
        8'd30:   c = 8'h21;
        8'd31:   c = 8'h40;
        8'd32:   c = 8'h23;
        8'd33:   c = 8'h24;
        8'd34:   c = 8'h25;
        8'd35:   c = 8'h5E;
        8'd36:   c = 8'h26;
        8'd37:   c = 8'h2A;
        8'd38:   c = 8'h28;
        8'd39:   c = 8'h29;
        8'd44:   c = 8'h20;
        8'd45:   c = 8'h5F;
        8'd46:   c = 8'h2B;
        8'd47:   c = 8'h7B;
        8'd48:   c = 8'h7D;
        8'd49:   c = 8'h3F;
        8'd50:   c = 8'h7C;
        8'd51:   c = 8'h3A;
        8'd52:   c = 8'h22;
        8'd53:   c = 8'h7E;
        8'd54:   c = 8'h3C;
        8'd55:   c = 8'h3E;
        8'd56:   c = 8'h3F;
        default: c = CHAR_NONE;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/hkle_front.sv -----
`timescale 1ns / 1ps

module hkle_front #(
  parameter int KEYS_PER_REPORT = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                report_valid,
  output logic                report_ready,
  input  logic [1:0]          kind,
  input  logic [7:0]          modifiers,
  input  logic [5:0][7:0]     keys_in,
  output logic                push,
  output hkle_pkg::key_op_t   push_op,
  input  logic                full
);

  localparam int IDX_W = (KEYS_PER_REPORT > 1) ? $clog2(KEYS_PER_REPORT) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(KEYS_PER_REPORT - 1);

  logic                 busy;
  logic [IDX_W-1:0]     slot;
  logic                 shift;
  logic [7:0]           keys [KEYS_PER_REPORT];

  logic [7:0]           code;
  logic [7:0]           ch;
  logic                 has_op;
  logic                 advance;
  logic                 accept;

  assign report_ready = !busy;
  assign accept       = report_valid && report_ready;

  // Classify the key in the current slot
  always_comb begin
    code          = keys[slot];
    ch            = shift ? hkle_pkg::shift_char(code) : hkle_pkg::plain_char(code);
    has_op        = 1'b0;
    push_op.kind  = hkle_pkg::OP_CHAR;
    push_op.ch    = ch;
    if (code == hkle_pkg::KEY_ENTER) begin
      has_op       = 1'b1;
      push_op.kind = hkle_pkg::OP_ENTER;
    end else if (code == hkle_pkg::KEY_BACKSPACE) begin
      has_op       = 1'b1;
      push_op.kind = hkle_pkg::OP_BKSP;
    end else if (hkle_pkg::plain_char(code) != hkle_pkg::CHAR_NONE) begin
      has_op       = 1'b1;
    end
  end

  // Skip empty slots; wait on a full queue
  assign push    = busy && has_op && !full;
  assign advance = busy && (!has_op || !full);

  // Latch the report and walk its slots
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (accept) begin
      busy <= (kind == hkle_pkg::KIND_PRESS);
      slot <= '0;
    end else if (advance) begin
      if (slot == LAST_SLOT) begin
        busy <= 1'b0;
      end
      slot <= slot + IDX_W'(1);
    end
  end

  // Hold the report payload
  always_ff @(posedge clk) begin
    if (accept) begin
      shift <= modifiers[1] | modifiers[5];
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
        keys[i] <= keys_in[i];
      end
    end
  end

endmodule

// ----- hw/rtl/hkle_queue.sv -----
`timescale 1ns / 1ps

module hkle_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hkle_pkg::key_op_t push_op,
  output logic              full,
  input  logic              pop,
  output hkle_pkg::key_op_t pop_op,
  output logic              empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  hkle_pkg::key_op_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    fill;

  assign full   = (fill == (PTR_W+1)'(DEPTH));
  assign empty  = (fill == '0);
  assign pop_op = entries[rd_ptr];

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

  // Store the pushed op
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- hw/rtl/hkle_back.sv -----
`timescale 1ns / 1ps

module hkle_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  hkle_pkg::key_op_t pop_op,
  input  logic              empty,
  output logic              pop,
  output logic              chunk_valid,
  input  logic              chunk_ready,
  output logic [63:0]       line_chunk,
  output logic [3:0]        chunk_bytes,
  output logic [6:0]        line_length,
  output logic              last
);

  localparam int PTR_W = $clog2(LINE_CAPACITY);
  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LINE_CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(LINE_CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(LINE_CAPACITY);
  localparam logic [3:0]       CHUNK_N  = 4'(hkle_pkg::CHUNK_CHARS);

  hkle_pkg::back_state_t state, state_next;

  logic [7:0]       mem [LINE_CAPACITY];
  logic [7:0]       mem_q;

  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] head, head_next;
  logic             typing, typing_next;
  logic [PTR_W-1:0] rptr, rptr_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic [3:0]       nbytes, nbytes_next;
  logic [63:0]      chunk, chunk_next;
  logic             last_r, last_next;

  logic             we;
  logic [PTR_W-1:0] waddr;
  logic             re;
  logic [SUM_W-1:0] tail_sum;
  logic             take_char;
  logic [CNT_W+6:0] len_ext;

  // Tail position of the ring: head plus count, wrapped once
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= CAP_SUM) begin
      tail_sum = tail_sum - CAP_SUM;
    end
    waddr = tail_sum[PTR_W-1:0];
  end

  assign take_char = typing || (pop_op.ch == hkle_pkg::CHAR_SLASH);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hkle_pkg::BK_IDLE: begin
        if (!empty && pop_op.kind == hkle_pkg::OP_ENTER && typing) begin
          state_next = (count == '0) ? hkle_pkg::BK_OUT : hkle_pkg::BK_ADDR;
        end
      end
      hkle_pkg::BK_ADDR: begin
        state_next = hkle_pkg::BK_DATA;
      end
      hkle_pkg::BK_DATA: begin
        if (remaining == '0 || nbytes + 4'd1 == CHUNK_N) begin
          state_next = hkle_pkg::BK_OUT;
        end else begin
          state_next = hkle_pkg::BK_ADDR;
        end
      end
      hkle_pkg::BK_OUT: begin
        if (chunk_ready) begin
          state_next = last_r ? hkle_pkg::BK_IDLE : hkle_pkg::BK_ADDR;
        end
      end
      default: state_next = hkle_pkg::BK_IDLE;
    endcase
  end

  // Datapath and handshake outputs
  always_comb begin
    count_next     = count;
    head_next      = head;
    typing_next    = typing;
    rptr_next      = rptr;
    remaining_next = remaining;
    nbytes_next    = nbytes;
    chunk_next     = chunk;
    last_next      = last_r;
    pop            = 1'b0;
    we             = 1'b0;
    re             = 1'b0;
    case (state)
      hkle_pkg::BK_IDLE: begin
        pop = !empty;
        if (!empty) begin
          case (pop_op.kind)
            hkle_pkg::OP_CHAR: begin
              // Append; a full line drops its oldest character
              if (take_char) begin
                we          = 1'b1;
                typing_next = 1'b1;
                if (count == CAP_CNT) begin
                  head_next = (head == LAST_PTR) ? '0 : head + PTR_W'(1);
                end else begin
                  count_next = count + CNT_W'(1);
                end
              end
            end
            hkle_pkg::OP_BKSP: begin
              if (typing && count != '0) begin
                count_next = count - CNT_W'(1);
              end
            end
            hkle_pkg::OP_ENTER: begin
              if (typing) begin
                rptr_next      = head;
                remaining_next = count;
                nbytes_next    = '0;
                chunk_next     = '0;
                last_next      = (count == '0);
              end
            end
            default: begin
            end
          endcase
        end
      end
      hkle_pkg::BK_ADDR: begin
        // Read one character of the line
        re             = 1'b1;
        rptr_next      = (rptr == LAST_PTR) ? '0 : rptr + PTR_W'(1);
        remaining_next = remaining - CNT_W'(1);
      end
      hkle_pkg::BK_DATA: begin
        // Pack the read character into the chunk
        chunk_next[nbytes[2:0]*8 +: 8] = mem_q;
        nbytes_next                   = nbytes + 4'd1;
        last_next                     = (remaining == '0);
      end
      hkle_pkg::BK_OUT: begin
        if (chunk_ready) begin
          if (last_r) begin
            count_next  = '0;
            head_next   = '0;
            typing_next = 1'b0;
          end else begin
            nbytes_next = '0;
            chunk_next  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= hkle_pkg::BK_IDLE;
      count  <= '0;
      head   <= '0;
      typing <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      head   <= head_next;
      typing <= typing_next;
    end
  end

  // Emission payload registers
  always_ff @(posedge clk) begin
    rptr      <= rptr_next;
    remaining <= remaining_next;
    nbytes    <= nbytes_next;
    chunk     <= chunk_next;
    last_r    <= last_next;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= pop_op.ch;
    end
    if (re) begin
      mem_q <= mem[rptr];
    end
  end

  assign len_ext     = (CNT_W+7)'(count);
  assign chunk_valid = (state == hkle_pkg::BK_OUT);
  assign line_chunk  = chunk;
  assign chunk_bytes = nbytes;
  assign line_length = len_ext[6:0];
  assign last        = last_r;

endmodule

// ----- hw/rtl/hid_keyboard_line_editor.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// report    report_valid/report_ready  kind, modifiers, key_0..key_5
// chunk     chunk_valid/chunk_ready    line_chunk, chunk_bytes, line_length, last
//
// A press report walks one slot per cycle while the 4-deep op queue has room; no new
// report is taken before its last slot; any other report frees the port at once.
// The line engine stores a character or handles backspace while idle; on enter it reads
// each character via an address and a data state (one store read port) into chunk beats.
// Reset clears the line, typing mode and both handshakes; the store needs no clearing.
// A stalled chunk holds the engine while the front end fills the queue up to full.

module hid_keyboard_line_editor #(
  parameter int LINE_CAPACITY   = 64,
  parameter int KEYS_PER_REPORT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        report_valid,
  output logic        report_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  modifiers,
  input  logic [7:0]  key_0,
  input  logic [7:0]  key_1,
  input  logic [7:0]  key_2,
  input  logic [7:0]  key_3,
  input  logic [7:0]  key_4,
  input  logic [7:0]  key_5,
  output logic        chunk_valid,
  input  logic        chunk_ready,
  output logic [63:0] line_chunk,
  output logic [3:0]  chunk_bytes,
  output logic [6:0]  line_length,
  output logic        last
);

  logic [5:0][7:0]   keys_in;
  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  hkle_pkg::key_op_t push_op;
  hkle_pkg::key_op_t pop_op;

  assign keys_in = {key_5, key_4, key_3, key_2, key_1, key_0};

  // Classify reports into key ops
  hkle_front #(
    .KEYS_PER_REPORT (KEYS_PER_REPORT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .kind         (kind),
    .modifiers    (modifiers),
    .keys_in      (keys_in),
    .push         (push),
    .push_op      (push_op),
    .full         (full)
  );

  // Decouple front end and line engine
  hkle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (empty)
  );

  // Edit the line and emit chunks
  hkle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_op      (pop_op),
    .empty       (empty),
    .pop         (pop),
    .chunk_valid (chunk_valid),
    .chunk_ready (chunk_ready),
    .line_chunk  (line_chunk),
    .chunk_bytes (chunk_bytes),
    .line_length (line_length),
    .last        (last)
  );

endmodule

// ----- hw/rtl/hkle_checker.sv -----
`timescale 1ns / 1ps

module hkle_checker (
  input logic        clk,
  input logic        rst,
  input logic        chunk_valid,
  input logic        chunk_ready,
  input logic [63:0] line_chunk,
  input logic [3:0]  chunk_bytes,
  input logic [6:0]  line_length,
  input logic        last
);

  // Hold a stalled chunk beat
  a_chunk_hold: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !chunk_ready |=> chunk_valid && $stable(line_chunk) && $stable(last))
    else $error("stalled chunk beat changed");

  // Only the final chunk of a line may be short
  a_full_chunk: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !last |-> chunk_bytes == 4'd8)
    else $error("non-final chunk is not full");

  // An empty chunk is only the lone beat of an empty line
  a_empty_line: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && chunk_bytes == 4'd0 |-> last && line_length == 7'd0 && line_chunk == 64'd0)
    else $error("empty chunk outside an empty line");

  // No chunk right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !chunk_valid)
    else $error("chunk valid after reset");

endmodule

bind hid_keyboard_line_editor hkle_checker u_hkle_checker (
  .clk         (clk),
  .rst         (rst),
  .chunk_valid (chunk_valid),
  .chunk_ready (chunk_ready),
  .line_chunk  (line_chunk),
  .chunk_bytes (chunk_bytes),
  .line_length (line_length),
  .last        (last)
);

// ----- test/hkle_line_checker.sv -----
`timescale 1ns / 1ps

// Watches the report and chunk channels, predicts the chunks of every
// accepted line and compares each chunk beat with the oldest prediction.
module hkle_line_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        report_valid,
  input  logic        report_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  modifiers,
  input  logic [7:0]  key_0,
  input  logic [7:0]  key_1,
  input  logic [7:0]  key_2,
  input  logic [7:0]  key_3,
  input  logic [7:0]  key_4,
  input  logic [7:0]  key_5,
  input  logic        chunk_valid,
  input  logic        chunk_ready,
  input  logic [63:0] line_chunk,
  input  logic [3:0]  chunk_bytes,
  input  logic [6:0]  line_length,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  localparam int LINE_DEPTH = 64;

  typedef struct packed {
    logic [63:0] text;
    logic [3:0]  bytes;
    logic [6:0]  len;
    logic        fin;
  } line_chunk_t;

  line_chunk_t expected_chunks[$];

  // Predicted editor state
  logic [7:0] line_buf [LINE_DEPTH];
  int         line_len;
  logic       typing;

  // Character for a key code, zero where the key types nothing
  function automatic logic [7:0] key_char(input logic [7:0] code, input logic shifted);
    string      plain_punct  = " -=[]?\\;'~,./";
    string      shift_punct  = " _+{}?|:\"~<>?";
    string      shift_digits = "!@#$%^&*()";
    logic [7:0] c;
    c = 8'h00;
    if (code >= 8'd4 && code <= 8'd29) begin
      c = (shifted ? 8'h41 : 8'h61) + (code - 8'd4);
    end else if (code >= 8'd30 && code <= 8'd39) begin
      if (shifted) begin
        c = shift_digits[code - 8'd30];
      end else begin
        c = (code == 8'd39) ? 8'h30 : 8'h31 + (code - 8'd30);
      end
    end else if (code >= 8'd44 && code <= 8'd56) begin
      c = shifted ? shift_punct[code - 8'd44] : plain_punct[code - 8'd44];
    end
    return c;
  endfunction

  // Split the current line into chunks of eight and queue them
  task automatic queue_line();
    line_chunk_t item;
    int          pos;
    int          b;
    pos = 0;
    do begin
      item.text = '0;
      b = 0;
      while (b < hkle_pkg::CHUNK_CHARS && pos + b < line_len) begin
        item.text[8*b +: 8] = line_buf[pos + b];
        b++;
      end
      pos += b;
      item.bytes = b[3:0];
      item.len   = line_len[6:0];
      item.fin   = (pos >= line_len);
      expected_chunks.push_back(item);
    end while (pos < line_len);
  endtask

  // Walk one press report slot by slot
  task automatic edit_line(input logic [7:0] mods, input logic [47:0] keys);
    logic       shifted;
    logic [7:0] code;
    logic [7:0] c;
    shifted = (mods & 8'h22) != 8'h00;
    for (int s = 0; s < 6; s++) begin
      code = keys[8*s +: 8];
      c    = key_char(code, shifted);
      if (code == hkle_pkg::KEY_NONE) begin
        continue;
      end else if (code == hkle_pkg::KEY_ENTER) begin
        if (typing) begin
          queue_line();
          line_len = 0;
          typing   = 1'b0;
        end
      end else if (code == hkle_pkg::KEY_BACKSPACE) begin
        if (typing && line_len != 0) begin
          line_len--;
        end
      end else if (c != hkle_pkg::CHAR_NONE && (typing || c == hkle_pkg::CHAR_SLASH)) begin
        typing = 1'b1;
        // drop the oldest character of a full line
        if (line_len >= LINE_DEPTH) begin
          for (int i = 0; i < LINE_DEPTH - 1; i++) begin
            line_buf[i] = line_buf[i + 1];
          end
          line_len = LINE_DEPTH - 1;
        end
        line_buf[line_len] = c;
        line_len++;
      end
    end
  endtask

  // Compare the chunk beat first, then predict from the report beat
  always @(posedge clk) begin
    line_chunk_t want;
    if (rst) begin
      expected_chunks.delete();
      line_len   = 0;
      typing     = 1'b0;
      fail_count = 0;
      pending    = 0;
    end else begin
      if (chunk_valid && chunk_ready) begin
        if (expected_chunks.size() == 0) begin
          $display("%0t ns: chunk with none expected: chunk %h bytes %0d length %0d last %0d",
                   $time, line_chunk, chunk_bytes, line_length, last);
          fail_count++;
        end else begin
          want = expected_chunks.pop_front();
          if ({line_chunk, chunk_bytes, line_length, last} !== want) begin
            $display("%0t ns: expected chunk %h bytes %0d length %0d last %0d",
                     $time, want.text, want.bytes, want.len, want.fin);
            $display("%0t ns: actual   chunk %h bytes %0d length %0d last %0d",
                     $time, line_chunk, chunk_bytes, line_length, last);
            fail_count++;
          end
        end
      end
      if (report_valid && report_ready && kind == hkle_pkg::KIND_PRESS) begin
        edit_line(modifiers, {key_5, key_4, key_3, key_2, key_1, key_0});
      end
      pending = expected_chunks.size();
    end
  end

endmodule

// ----- test/tb_hid_keyboard_line_editor.sv -----
`timescale 1ns / 1ps

module tb_hid_keyboard_line_editor;

  localparam logic [1:0] KIND_CONNECT    = 2'd0;
  localparam logic [1:0] KIND_DISCONNECT = 2'd1;
  localparam logic [1:0] KIND_RESERVED   = 2'd3;
  localparam logic [7:0] KEY_A           = 8'd4;
  localparam logic [7:0] KEY_SLASH       = 8'd56;
  localparam logic [7:0] SHIFT_BITS      = 8'h22;
  localparam int         RANDOM_PRESSES  = 470;
  localparam int         CYCLE_LIMIT     = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        report_valid = 1'b0;
  logic        report_ready;
  logic [1:0]  kind = KIND_CONNECT;
  logic [7:0]  modifiers = 8'h00;
  logic [7:0]  key_0 = 8'h00;
  logic [7:0]  key_1 = 8'h00;
  logic [7:0]  key_2 = 8'h00;
  logic [7:0]  key_3 = 8'h00;
  logic [7:0]  key_4 = 8'h00;
  logic [7:0]  key_5 = 8'h00;
  logic        chunk_valid;
  logic        chunk_ready = 1'b0;
  logic [63:0] line_chunk;
  logic [3:0]  chunk_bytes;
  logic [6:0]  line_length;
  logic        last;

  int fail_count;
  int pending;
  int send_idle_pct = 17;
  int recv_idle_pct = 47;
  int press_count   = 0;
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hid_keyboard_line_editor i_dut (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .kind         (kind),
    .modifiers    (modifiers),
    .key_0        (key_0),
    .key_1        (key_1),
    .key_2        (key_2),
    .key_3        (key_3),
    .key_4        (key_4),
    .key_5        (key_5),
    .chunk_valid  (chunk_valid),
    .chunk_ready  (chunk_ready),
    .line_chunk   (line_chunk),
    .chunk_bytes  (chunk_bytes),
    .line_length  (line_length),
    .last         (last)
  );

  hkle_line_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .kind         (kind),
    .modifiers    (modifiers),
    .key_0        (key_0),
    .key_1        (key_1),
    .key_2        (key_2),
    .key_3        (key_3),
    .key_4        (key_4),
    .key_5        (key_5),
    .chunk_valid  (chunk_valid),
    .chunk_ready  (chunk_ready),
    .line_chunk   (line_chunk),
    .chunk_bytes  (chunk_bytes),
    .line_length  (line_length),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Stall the chunk channel at random
  always @(posedge clk) begin
    chunk_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Hold one report beat until accepted, after an optional random gap
  task automatic send_report(input logic [1:0] k, input logic [7:0] m, input logic [47:0] keys);
    while ($urandom_range(99) < send_idle_pct) begin
      report_valid <= 1'b0;
      @(posedge clk);
    end
    report_valid <= 1'b1;
    kind         <= k;
    modifiers    <= m;
    {key_5, key_4, key_3, key_2, key_1, key_0} <= keys;
    do @(posedge clk); while (!report_ready);
    if (k == hkle_pkg::KIND_PRESS) begin
      press_count++;
    end
  endtask

  // Mostly typing keys, with some editing keys, empty slots and noise
  function automatic logic [7:0] typed_key();
    int         r;
    logic [7:0] code;
    r = $urandom_range(99);
    if (r < 70) begin
      code = 8'($urandom_range(4, 56));
      if (code >= 8'd40 && code <= 8'd43) begin
        code = 8'($urandom_range(4, 39));
      end
    end else if (r < 80) begin
      code = hkle_pkg::KEY_BACKSPACE;
    end else if (r < 88) begin
      code = hkle_pkg::KEY_NONE;
    end else if (r < 94) begin
      code = 8'($urandom_range(255));
    end else if (r < 98) begin
      code = KEY_SLASH;
    end else begin
      code = hkle_pkg::KEY_ENTER;
    end
    return code;
  endfunction

  function automatic logic [47:0] typed_row();
    logic [47:0] keys;
    for (int s = 0; s < 6; s++) begin
      keys[8*s +: 8] = typed_key();
    end
    return keys;
  endfunction

  // Open a line with '/', type a while, close it with enter
  task automatic type_line();
    logic [7:0]  mods;
    logic [47:0] keys;
    int          rows;
    mods = 8'($urandom_range(255));
    mods = mods & ~SHIFT_BITS;
    keys = typed_row();
    keys[7:0] = KEY_SLASH;
    send_report(hkle_pkg::KIND_PRESS, mods, keys);
    rows = ($urandom_range(7) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 8);
    repeat (rows) begin
      send_report(hkle_pkg::KIND_PRESS, 8'($urandom_range(255)), typed_row());
    end
    keys = typed_row();
    keys[8*$urandom_range(5) +: 8] = hkle_pkg::KEY_ENTER;
    send_report(hkle_pkg::KIND_PRESS, 8'($urandom_range(255)), keys);
  endtask

  initial begin
    logic [47:0] keys;
    logic [7:0]  code;
    logic [7:0]  mods;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reports other than presses are ignored
    send_report(KIND_CONNECT, 8'h00, {40'h0, KEY_SLASH});
    send_report(KIND_DISCONNECT, 8'hFF, {32'h0, KEY_A, KEY_SLASH});
    send_report(KIND_RESERVED, 8'hFF, {48{1'b1}});
    // Editing keys and ordinary characters do nothing outside typing mode
    send_report(hkle_pkg::KIND_PRESS, 8'h00,
                {8'hFF, hkle_pkg::KEY_NONE, 8'd41, KEY_A, hkle_pkg::KEY_BACKSPACE,
                 hkle_pkg::KEY_ENTER});
    // Shifted slash types '?', which does not open a line
    send_report(hkle_pkg::KIND_PRESS, 8'h02, {40'h0, KEY_SLASH});
    // Type, rub out one character, accept
    send_report(hkle_pkg::KIND_PRESS, 8'h00,
                {hkle_pkg::KEY_ENTER, hkle_pkg::KEY_BACKSPACE, 8'd6, 8'd5, KEY_A, KEY_SLASH});
    // Backspace past the start of the line, then accept the empty line
    send_report(hkle_pkg::KIND_PRESS, 8'h00,
                {16'h0, hkle_pkg::KEY_ENTER, hkle_pkg::KEY_BACKSPACE,
                 hkle_pkg::KEY_BACKSPACE, KEY_SLASH});
    // Keys without a character are skipped while typing
    send_report(hkle_pkg::KIND_PRESS, 8'hDD, {8'd43, 8'd41, 8'd3, 8'd2, 8'd1, KEY_SLASH});
    send_report(hkle_pkg::KIND_PRESS, 8'h20,
                {hkle_pkg::KEY_BACKSPACE, 8'd200, 8'd128, 8'hFF, 8'd58, 8'd57});
    send_report(hkle_pkg::KIND_PRESS, 8'h00, {40'h0, hkle_pkg::KEY_ENTER});

    // Overfill the line with every character key, plain and shifted
    for (int j = 0; j < 13; j++) begin
      case (j % 4)
        0:       mods = 8'h00;
        1:       mods = 8'h02;
        2:       mods = 8'h20;
        default: mods = 8'hDD;
      endcase
      for (int s = 0; s < 6; s++) begin
        code = 8'(4 + ((j * 6 + s) % 53));
        if (code == hkle_pkg::KEY_ENTER || code == hkle_pkg::KEY_BACKSPACE) begin
          code = 8'd44;
        end
        keys[8*s +: 8] = code;
      end
      if (j == 0) begin
        keys[7:0] = KEY_SLASH;
      end
      send_report(hkle_pkg::KIND_PRESS, mods, keys);
    end
    // Full line plus two lines of a lone slash in one report
    send_report(hkle_pkg::KIND_PRESS, 8'h00,
                {hkle_pkg::KEY_NONE, hkle_pkg::KEY_ENTER, KEY_SLASH, hkle_pkg::KEY_ENTER,
                 KEY_SLASH, hkle_pkg::KEY_ENTER});

    // Random lines and noise, across three idling phases
    press_count = 0;
    while (press_count < RANDOM_PRESSES) begin
      if (press_count >= 2 * RANDOM_PRESSES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (press_count >= RANDOM_PRESSES / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) begin
          send_report(2'($urandom_range(3)), 8'($urandom_range(255)),
                      {8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255))});
        end
      end else begin
        type_line();
      end
    end
    report_valid <= 1'b0;

    // Drain, then allow for a long line still being worked through
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/hkle_pkg.sv
hw/rtl/hkle_front.sv
hw/rtl/hkle_queue.sv
hw/rtl/hkle_back.sv
hw/rtl/hid_keyboard_line_editor.sv
hw/rtl/hkle_checker.sv
test/hkle_line_checker.sv
test/tb_hid_keyboard_line_editor.sv
